FILE: rtl/fsh_pkg.sv
package fsh_pkg;

	localparam int HalfSide = 8;
	localparam int Side     = 2 * HalfSide;
	localparam int CoordW   = $clog2(Side);
	localparam int CellW    = 2 * CoordW;

	localparam logic [15:0] SeedAtReset = 16'd44257;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [Side-1:0]   row_t;

	typedef enum logic [1:0] {
		KIND_ORIENT = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_DROP   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_ANY   = 2'd0,
		MODE_UPPER = 2'd1,
		MODE_LOWER = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDM,
		ST_RDC,
		ST_RDP,
		ST_DEC,
		ST_WRS,
		ST_WRD,
		ST_ORD,
		ST_OWR
	} state_t;

	// one cell visit handed to the mover
	typedef struct packed {
		logic [1:0] quad;
		coord_t     x;
		coord_t     y;
		logic       fwd;
		logic       side_en;
		mode_t      mode;
	} cell_req_t;

	// decision of the mover for one cell
	typedef struct packed {
		logic       moved;
		logic       same_row;
		logic       tie;
		coord_t     dst_y;
		row_t       src_row;
		row_t       dst_row;
		logic [15:0] lfsr_next;
	} move_t;

	// reset row content: columns 0..HalfSide-2 filled in upper rows
	function automatic row_t reset_row(coord_t y);
		row_t r;
		r = '0;
		if (int'(y) >= HalfSide) begin
			r[HalfSide-2:0] = '1;
		end
		return r;
	endfunction

endpackage

FILE: rtl/fsh_in_if.sv
interface fsh_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;

	modport source (output valid, output kind, output accel_x, output accel_y, input ready);
	modport sink (input valid, input kind, input accel_x, input accel_y, output ready);
endinterface

FILE: rtl/fsh_out_if.sv
interface fsh_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_index;
	logic [7:0] row_bits;
	logic       last_row;

	modport source (output valid, output row_index, output row_bits, output last_row, input ready);
	modport sink (input valid, input row_index, input row_bits, input last_row, output ready);
endinterface

FILE: rtl/fsh_row_ram.sv
module fsh_row_ram (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  fsh_pkg::coord_t rd_addr,
	output fsh_pkg::row_t  rd_data,
	input  logic           wr_en,
	input  fsh_pkg::coord_t wr_addr,
	input  fsh_pkg::row_t  wr_data
);
	import fsh_pkg::*;

	row_t             mem [Side];
	logic [Side-1:0]  valid_q;
	row_t             mem_rd_q;
	logic             vld_rd_q;
	coord_t           addr_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q  <= mem[rd_addr];
			addr_rd_q <= rd_addr;
		end
	end

	// a row never written reads as its reset content
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : reset_row(addr_rd_q);
endmodule

FILE: rtl/fsh_mover.sv
module fsh_mover (
	input  fsh_pkg::cell_req_t req,
	input  fsh_pkg::row_t      row_m,
	input  fsh_pkg::row_t      row_c,
	input  fsh_pkg::row_t      row_p,
	input  logic [15:0]        lfsr,
	output fsh_pkg::move_t     mv
);
	import fsh_pkg::*;

	typedef logic signed [CoordW+1:0] scoord_t;

	logic signed [1:0] fdx, fdy, ldx, ldy, rdx, rdy;
	scoord_t sx, sy;
	logic    cur, f_ok, l_ok, r_ok, go_left;
	logic signed [1:0] tdx, tdy;
	scoord_t tx, ty;
	logic    fb;

	always_comb begin
		case (req.quad)
			2'd0: begin fdx = 2'sd1;  fdy = -2'sd1; ldx = 2'sd0;  ldy = -2'sd1;
				rdx = 2'sd1; rdy = 2'sd0; end
			2'd1: begin fdx = 2'sd1;  fdy = 2'sd1;  ldx = 2'sd1;  ldy = 2'sd0;
				rdx = 2'sd0; rdy = 2'sd1; end
			2'd2: begin fdx = -2'sd1; fdy = 2'sd1;  ldx = -2'sd1; ldy = 2'sd0;
				rdx = 2'sd0; rdy = 2'sd1; end
			default: begin fdx = -2'sd1; fdy = -2'sd1; ldx = -2'sd1; ldy = 2'sd0;
				rdx = 2'sd0; rdy = -2'sd1; end
		endcase
	end

	function automatic row_t pick_row(logic signed [1:0] dy, row_t m, row_t c, row_t p);
		row_t r;
		case (dy)
			-2'sd1:  r = m;
			2'sd1:   r = p;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic is_free(scoord_t x, scoord_t y, logic signed [1:0] dy,
		mode_t mode, row_t m, row_t c, row_t p);
		logic up, lo, ok;
		row_t r;
		up = (x >= 0) && (x < scoord_t'(HalfSide)) && (y >= scoord_t'(HalfSide))
			&& (y < scoord_t'(Side));
		lo = (x >= scoord_t'(HalfSide)) && (x < scoord_t'(Side)) && (y >= 0)
			&& (y < scoord_t'(HalfSide));
		case (mode)
			MODE_UPPER: ok = up;
			MODE_LOWER: ok = lo;
			default:    ok = up || lo;
		endcase
		r = pick_row(dy, m, c, p);
		return ok && !r[x[CoordW-1:0]];
	endfunction

	always_comb begin
		sx   = scoord_t'({2'b00, req.x});
		sy   = scoord_t'({2'b00, req.y});
		cur  = row_c[req.x];
		f_ok = req.fwd && is_free(sx + scoord_t'(fdx), sy + scoord_t'(fdy), fdy, MODE_ANY,
			row_m, row_c, row_p);
		l_ok = req.side_en && is_free(sx + scoord_t'(ldx), sy + scoord_t'(ldy), ldy,
			req.mode, row_m, row_c, row_p);
		r_ok = req.side_en && is_free(sx + scoord_t'(rdx), sy + scoord_t'(rdy), rdy,
			req.mode, row_m, row_c, row_p);
		fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
		mv.lfsr_next = {fb, lfsr[15:1]};
		mv.tie  = cur && !f_ok && l_ok && r_ok;
		go_left = mv.tie ? !lfsr[1] : l_ok;
		if (f_ok) begin
			tdx = fdx; tdy = fdy;
		end else if (go_left) begin
			tdx = ldx; tdy = ldy;
		end else begin
			tdx = rdx; tdy = rdy;
		end
		mv.moved    = cur && (f_ok || l_ok || r_ok);
		tx          = sx + scoord_t'(tdx);
		ty          = sy + scoord_t'(tdy);
		mv.dst_y    = ty[CoordW-1:0];
		mv.same_row = (tdy == 2'sd0);
		mv.src_row  = row_c;
		mv.src_row[req.x] = 1'b0;
		if (mv.same_row) begin
			mv.src_row[tx[CoordW-1:0]] = 1'b1;
		end
		mv.dst_row = pick_row(tdy, row_m, row_c, row_p);
		mv.dst_row[tx[CoordW-1:0]] = 1'b1;
	end
endmodule

FILE: rtl/falling_sand_hourglass_grid.sv
// Falling-sand hourglass grain map, 16x16 cells in two 8x8 regions joined at the neck.
// in_ch (sink) takes one word per command: kind 0 sets gravity from the accel signs,
// kind 1 runs a frame step, kind 2 passes one grain through the neck, kind 3 is dropped.
// out_ch (source) gives 16 row words after each frame step, row 0 first, last_row on 15.
// cfg_we/cfg_wdata load the tie-break LFSR seed (zero loads the reset seed).
// The map lives in a 16-row by 16-bit RAM with a registered read port.
// Each cell visit reads the rows above, at and below the cell (three reads), decides,
// then, if the grain moves, writes the source row and, for a move across rows, the
// target row. Quadrants 0 and 2 visit 128 cells, quadrants 1 and 3 all 256; the
// readout then reads each row in turn into the output register.
// An orientation word only sets the quadrant; a drop tick runs one cell visit at the
// neck in quadrants 0 and 2 and does nothing in quadrants 1 and 3.
// in_ch.ready is high only while the sequencer is idle; one command runs at a time.
// A stalled receiver holds the row word in the output register and the readout waits.
// Reset: per-row valid bits make the RAM read as the initial sand load at once, so no
// clearing pass is needed; gravity goes to quadrant 0 and the LFSR to its reset seed.
module falling_sand_hourglass_grid (
	input  logic        clk,
	input  logic        arst_n,
	fsh_in_if.sink      in_ch,
	fsh_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import fsh_pkg::*;

	state_t      state_q, state_d;
	logic [1:0]  quad_q;
	logic [15:0] lfsr_q;
	logic [CellW-1:0] cnt_q;
	logic        drop_q;
	coord_t      orow_q;
	row_t        row_m_q, row_c_q;
	move_t       mv, mv_q;
	cell_req_t   req;

	logic        rd_en, wr_en;
	coord_t      rd_addr, wr_addr;
	row_t        rd_data, wr_data;
	logic        out_free, in_acc, last_cell;

	logic        out_valid_q;
	logic [3:0]  out_index_q;
	logic [7:0]  out_bits_q;
	logic        out_last_q;

	localparam int RegBits = CellW - 2;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// map scan index and quadrant to the cell, following each quadrant's visit order
	always_comb begin
		logic [RegBits-1:0] i;
		logic [CoordW-2:0]  a, b;
		logic               hi;
		i  = cnt_q[RegBits-1:0];
		a  = i[RegBits-1:CoordW-1];
		b  = i[CoordW-2:0];
		hi = cnt_q[RegBits];
		req.quad    = quad_q;
		req.side_en = !drop_q;
		req.fwd     = 1'b1;
		req.mode    = MODE_ANY;
		req.x       = '0;
		req.y       = '0;
		if (drop_q) begin
			req.x = (quad_q == 2'd0) ? coord_t'(HalfSide - 1) : coord_t'(HalfSide);
			req.y = (quad_q == 2'd0) ? coord_t'(HalfSide) : coord_t'(HalfSide - 1);
		end else begin
			case (quad_q)
				2'd0: begin
					req.y    = {hi, a};
					req.x    = {!hi, ~b};
					req.fwd  = !hi;
					req.mode = hi ? MODE_UPPER : MODE_LOWER;
				end
				2'd2: begin
					req.y    = hi ? {1'b1, ~a} : {1'b0, a};
					req.x    = hi ? {1'b0, ~b} : {1'b1, b};
					req.fwd  = hi;
					req.mode = hi ? MODE_UPPER : MODE_LOWER;
				end
				2'd1: begin
					req.x = cnt_q[CellW-1:CoordW];
					req.y = cnt_q[CoordW-1:0];
				end
				default: begin
					req.x = ~cnt_q[CellW-1:CoordW];
					req.y = ~cnt_q[CoordW-1:0];
				end
			endcase
		end
	end

	assign last_cell = (quad_q[0] == 1'b0) ? (cnt_q[RegBits:0] == '1) : (cnt_q == '1);

	fsh_mover u_mover (
		.req   (req),
		.row_m (row_m_q),
		.row_c (row_c_q),
		.row_p (rd_data),
		.lfsr  (lfsr_q),
		.mv    (mv)
	);

	fsh_row_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (kind_t'(in_ch.kind) == KIND_FRAME) begin
						state_d = ST_RDM;
					end else if (kind_t'(in_ch.kind) == KIND_DROP && quad_q[0] == 1'b0) begin
						state_d = ST_RDM;
					end
				end
			end
			ST_RDM: state_d = ST_RDC;
			ST_RDC: state_d = ST_RDP;
			ST_RDP: state_d = ST_DEC;
			ST_DEC: begin
				if (mv.moved) begin
					state_d = ST_WRS;
				end else if (drop_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = last_cell ? ST_ORD : ST_RDM;
				end
			end
			ST_WRS: begin
				if (!mv_q.same_row) begin
					state_d = ST_WRD;
				end else if (drop_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = last_cell ? ST_ORD : ST_RDM;
				end
			end
			ST_WRD: begin
				if (drop_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = last_cell ? ST_ORD : ST_RDM;
				end
			end
			ST_ORD: state_d = ST_OWR;
			ST_OWR: begin
				if (out_free) begin
					state_d = (orow_q == coord_t'(Side - 1)) ? ST_IDLE : ST_ORD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = req.y;
		wr_en   = 1'b0;
		wr_addr = req.y;
		wr_data = mv_q.src_row;
		case (state_q)
			ST_RDM: begin
				rd_en   = 1'b1;
				rd_addr = req.y - coord_t'(1);
			end
			ST_RDC: rd_en = 1'b1;
			ST_RDP: begin
				rd_en   = 1'b1;
				rd_addr = req.y + coord_t'(1);
			end
			ST_WRS: wr_en = 1'b1;
			ST_WRD: begin
				wr_en   = 1'b1;
				wr_addr = mv_q.dst_y;
				wr_data = mv_q.dst_row;
			end
			ST_ORD: begin
				rd_en   = 1'b1;
				rd_addr = orow_q;
			end
			default: rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quad_q      <= 2'd0;
			lfsr_q      <= SeedAtReset;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			orow_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lfsr_q <= (cfg_wdata == 16'd0) ? SeedAtReset : cfg_wdata;
			end
			// drop the word once taken, unless the next row word loads on the same edge
			if (out_valid_q && out_ch.ready && !(state_q == ST_OWR && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= '0;
						orow_q <= '0;
						drop_q <= (kind_t'(in_ch.kind) == KIND_DROP);
						if (kind_t'(in_ch.kind) == KIND_ORIENT) begin
							// gravity quadrant from the accel sign bits
							if (in_ch.accel_y[15] && !in_ch.accel_x[15]) begin
								quad_q <= 2'd0;
							end else if (!in_ch.accel_y[15] && !in_ch.accel_x[15]) begin
								quad_q <= 2'd1;
							end else if (!in_ch.accel_y[15] && in_ch.accel_x[15]) begin
								quad_q <= 2'd2;
							end else begin
								quad_q <= 2'd3;
							end
						end
					end
				end
				ST_DEC: begin
					if (mv.tie) begin
						lfsr_q <= mv.lfsr_next;
					end
					if (!mv.moved) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRS: begin
					if (mv_q.same_row) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRD: cnt_q <= cnt_q + 1'b1;
				ST_OWR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						orow_q      <= orow_q + 1'b1;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// window rows, decision latch and output row word
	always_ff @(posedge clk) begin
		if (state_q == ST_RDC) begin
			row_m_q <= rd_data;
		end
		if (state_q == ST_RDP) begin
			row_c_q <= rd_data;
		end
		if (state_q == ST_DEC) begin
			mv_q <= mv;
		end
		if (state_q == ST_OWR && out_free) begin
			out_index_q <= orow_q;
			out_bits_q  <= (int'(orow_q) < HalfSide) ? rd_data[Side-1:HalfSide]
				: rd_data[HalfSide-1:0];
			out_last_q  <= (orow_q == coord_t'(Side - 1));
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.row_index = out_index_q;
	assign out_ch.row_bits  = out_bits_q;
	assign out_ch.last_row  = out_last_q;

	// a frame command keeps the input side closed on the next cycle
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind_t'(in_ch.kind) == KIND_FRAME |=> !in_ch.ready)
		else $error("input ready right after a frame command");

	// the map is never written while idle
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("map write while idle");

	// the last row word of a frame is not directly followed by a further word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.last_row |=> !out_ch.valid)
		else $error("row word after the last row");
endmodule

FILE: tb/falling_sand_hourglass_grid_tb.sv
module falling_sand_hourglass_grid_tb;
	import fsh_pkg::*;

	// word on the command channel
	typedef struct {
		kind_t             kind;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
	} cmd_t;

	// one row report
	typedef struct {
		logic [3:0] idx;
		logic [7:0] bits;
		logic       last;
	} row_rep_t;

	localparam int WatchdogLimit = 40000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	fsh_in_if  in_ch ();
	fsh_out_if out_ch ();

	falling_sand_hourglass_grid u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch.sink),
		.out_ch   (out_ch.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state: map indexed [x][y]; the block keeps it as rows indexed by y
	logic        sand [Side][Side];
	logic [1:0]  quad;
	logic [15:0] lfsr;

	cmd_t     pending_cmds [$];
	row_rep_t expected_rows [$];
	int       err_count;
	int       rows_seen;
	int       frames_sent;
	int       idle_cycles;
	logic     drive_en;
	int       burst_left;
	int       gap_left;
	int       stall_phase;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic bit in_up(int x, int y);
		return x >= 0 && x < HalfSide && y >= HalfSide && y < Side;
	endfunction

	function automatic bit in_lo(int x, int y);
		return x >= HalfSide && x < Side && y >= 0 && y < HalfSide;
	endfunction

	function automatic bit cell_free(int x, int y, mode_t m);
		bit ok;
		if (m == MODE_UPPER) ok = in_up(x, y);
		else if (m == MODE_LOWER) ok = in_lo(x, y);
		else ok = in_up(x, y) || in_lo(x, y);
		return ok && !sand[x][y];
	endfunction

	// shift the tie LFSR once; report whether the grain goes left
	function automatic bit tie_left();
		logic fb;
		fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
		lfsr = {fb, lfsr[15:1]};
		return !lfsr[0];
	endfunction

	function automatic void step_grain(int x, int y, bit fwd, mode_t m);
		int fx, fy, lx, ly, rx, ry;
		bit cl, cr;
		case (quad)
			2'd0: begin fx = 1;  fy = -1; lx = 0;  ly = -1; rx = 1; ry = 0;  end
			2'd1: begin fx = 1;  fy = 1;  lx = 1;  ly = 0;  rx = 0; ry = 1;  end
			2'd2: begin fx = -1; fy = 1;  lx = -1; ly = 0;  rx = 0; ry = 1;  end
			default: begin fx = -1; fy = -1; lx = -1; ly = 0; rx = 0; ry = -1; end
		endcase
		if (!sand[x][y]) return;
		if (fwd && cell_free(x + fx, y + fy, MODE_ANY)) begin
			sand[x][y] = 0; sand[x + fx][y + fy] = 1;
			return;
		end
		cl = cell_free(x + lx, y + ly, m);
		cr = cell_free(x + rx, y + ry, m);
		if (cl && cr) begin
			if (tie_left()) begin sand[x][y] = 0; sand[x + lx][y + ly] = 1; end
			else begin sand[x][y] = 0; sand[x + rx][y + ry] = 1; end
		end else if (cl) begin
			sand[x][y] = 0; sand[x + lx][y + ly] = 1;
		end else if (cr) begin
			sand[x][y] = 0; sand[x + rx][y + ry] = 1;
		end
	endfunction

	function automatic void reset_sand();
		for (int x = 0; x < Side; x++)
			for (int y = 0; y < Side; y++)
				sand[x][y] = (x < HalfSide - 1) && (y >= HalfSide);
		quad = 2'd0;
		lfsr = SeedAtReset;
	endfunction

	// apply one command and queue the rows it causes
	function automatic void predict_cmd(cmd_t c);
		row_rep_t r;
		int base;
		case (c.kind)
			KIND_ORIENT: begin
				if (c.ay[15] && !c.ax[15]) quad = 2'd0;
				else if (!c.ay[15] && !c.ax[15]) quad = 2'd1;
				else if (!c.ay[15] && c.ax[15]) quad = 2'd2;
				else quad = 2'd3;
			end
			KIND_DROP: begin
				// neck pass: down-right in quadrant 0, mirrored in quadrant 2
				if (quad == 2'd0 && sand[7][8] && !sand[8][7]) begin
					sand[7][8] = 0; sand[8][7] = 1;
				end else if (quad == 2'd2 && sand[8][7] && !sand[7][8]) begin
					sand[8][7] = 0; sand[7][8] = 1;
				end
			end
			KIND_FRAME: begin
				case (quad)
					2'd0: begin
						for (int y = 0; y < HalfSide; y++)
							for (int x = Side - 1; x >= HalfSide; x--)
								step_grain(x, y, 1, MODE_LOWER);
						for (int y = HalfSide; y < Side; y++)
							for (int x = HalfSide - 1; x >= 0; x--)
								step_grain(x, y, 0, MODE_UPPER);
					end
					2'd2: begin
						for (int y = 0; y < HalfSide; y++)
							for (int x = HalfSide; x < Side; x++)
								step_grain(x, y, 0, MODE_LOWER);
						for (int y = Side - 1; y >= HalfSide; y--)
							for (int x = HalfSide - 1; x >= 0; x--)
								step_grain(x, y, 1, MODE_UPPER);
					end
					2'd1: begin
						for (int x = 0; x < Side; x++)
							for (int y = 0; y < Side; y++) step_grain(x, y, 1, MODE_ANY);
					end
					default: begin
						for (int x = Side - 1; x >= 0; x--)
							for (int y = Side - 1; y >= 0; y--) step_grain(x, y, 1, MODE_ANY);
					end
				endcase
				for (int y = 0; y < Side; y++) begin
					base = (y < HalfSide) ? HalfSide : 0;
					r.idx = y[3:0];
					for (int k = 0; k < HalfSide; k++) r.bits[k] = sand[base + k][y];
					r.last = (y == Side - 1);
					expected_rows.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		err_count++;
		$display("mismatch row %0d: %s got %0h want %0h", rows_seen, what, got, want);
	endtask

	// ---------------- stimulus helpers ----------------
	function automatic cmd_t mk(kind_t k, logic signed [15:0] ax, logic signed [15:0] ay);
		cmd_t c;
		c.kind = k; c.ax = ax; c.ay = ay;
		return c;
	endfunction

	// ---------------- driver ----------------
	// send in bursts; hold the word while ready is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.kind    <= KIND_ORIENT;
			in_ch.accel_x <= '0;
			in_ch.accel_y <= '0;
			burst_left    <= 0;
			gap_left      <= 0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid) predict_cmd(mk(kind_t'(in_ch.kind), in_ch.accel_x, in_ch.accel_y));
				if (gap_left > 0) begin
					in_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (drive_en && pending_cmds.size() > 0) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.kind    <= c.kind;
					in_ch.accel_x <= c.ax;
					in_ch.accel_y <= c.ay;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
					// start a gap after the last word of a burst, sometimes none
					if (burst_left == 1) begin
						if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(1, 12);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	// receiver follows a rotating pattern: a full-speed phase, then phases of random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase  <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_rows.size() == 0) begin
					report("unexpected row_index", 8'(out_ch.row_index), 8'd0);
				end else begin
					row_rep_t w;
					w = expected_rows.pop_front();
					if (out_ch.row_index !== w.idx) report("row_index", out_ch.row_index, w.idx);
					if (out_ch.row_bits !== w.bits) report("row_bits", out_ch.row_bits, w.bits);
					if (out_ch.last_row !== w.last) report("last_row", out_ch.last_row, w.last);
				end
				rows_seen++;
			end
			stall_phase <= (stall_phase + 1) % 64;
			if (stall_phase < 16) out_ch.ready <= 1'b1;
			else if (stall_phase < 40) out_ch.ready <= ($urandom_range(0, 3) != 0);
			else out_ch.ready <= ($urandom_range(0, 2) == 0);
		end
	end

	// watchdog: count cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("watchdog expired");
			$display("falling_sand_hourglass_grid_tb: errors");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic void add_cmd(cmd_t c);
		pending_cmds.push_back(c);
		if (c.kind == KIND_FRAME) frames_sent++;
	endfunction

	function automatic void add_orient(int q);
		logic signed [15:0] ax, ay;
		ax = 16'($urandom_range(0, 16'h7fff));
		ay = 16'($urandom_range(0, 16'h7fff));
		if (q == 0 || q == 3) ay[15] = 1;
		if (q == 2 || q == 3) ax[15] = 1;
		add_cmd(mk(KIND_ORIENT, ax, ay));
	endfunction

	// send queued words and wait for all rows, then hold for the block to settle
	task automatic drain();
		drive_en = 1'b1;
		while (pending_cmds.size() > 0 || in_ch.valid || expected_rows.size() > 0)
			@(posedge clk);
		drive_en = 1'b0;
		// a drop tick or orientation causes no rows; let a trailing command finish
		repeat (40) @(posedge clk);
	endtask

	task automatic write_seed(logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lfsr = (v == 16'd0) ? SeedAtReset : v;
	endtask

	// random phase: a random mix of frames, drops and tilts, some kind 3 and raw orientation words
	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 12) add_orient($urandom_range(0, 3));
			else if (r < 55) add_cmd(mk(KIND_FRAME, 16'($urandom), 16'($urandom)));
			else if (r < 88) add_cmd(mk(KIND_DROP, 16'($urandom), 16'($urandom)));
			else if (r < 94) add_cmd(mk(KIND_NONE, 16'($urandom), 16'($urandom)));
			else add_cmd(mk(KIND_ORIENT, 16'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		drive_en  = 1'b0;
		err_count = 0;
		rows_seen = 0;
		frames_sent = 0;
		idle_cycles = 0;
		reset_sand();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset map, every quadrant, field extremes, neck both ways, kind 3
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_ORIENT, 16'sh7fff, -16'sh8000));
		add_cmd(mk(KIND_DROP, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_DROP, -16'sh8000, 16'sh7fff));
		add_cmd(mk(KIND_FRAME, 16'shffff, 16'shffff));
		add_cmd(mk(KIND_NONE, 16'shffff, 16'shffff));
		add_cmd(mk(KIND_ORIENT, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_DROP, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_ORIENT, -16'sh8000, 16'sh7fff));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_DROP, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_ORIENT, 16'shffff, 16'shffff));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_DROP, 16'sh0000, 16'sh0000));
		add_cmd(mk(KIND_ORIENT, 16'sh0001, 16'shfffe));
		add_cmd(mk(KIND_FRAME, 16'sh0000, 16'sh0000));
		drain();

		// random phases across seed settings, extremes and the zero seed included
		write_seed(16'd1);
		random_phase(60);
		drain();
		write_seed(16'hffff);
		random_phase(60);
		drain();
		write_seed(16'd0);
		random_phase(60);
		drain();
		write_seed(16'($urandom_range(1, 65535)));
		random_phase(65);
		drain();
		write_seed(16'($urandom_range(1, 65535)));
		random_phase(65);
		drain();

		$display("covered %0d frames and %0d row words over five seed settings",
			frames_sent, rows_seen);
		if (err_count == 0) $display("falling_sand_hourglass_grid_tb: clean");
		else $display("falling_sand_hourglass_grid_tb: errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/fsh_pkg.sv
rtl/fsh_in_if.sv
rtl/fsh_out_if.sv
rtl/fsh_row_ram.sv
rtl/fsh_mover.sv
rtl/falling_sand_hourglass_grid.sv
tb/falling_sand_hourglass_grid_tb.sv
